@@ hw/rtl/cdg_pkg.sv @@
// Shared types and constants of the central-difference gradient unit.
package cdg_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IMG_W_W     = 12;
  localparam int unsigned IMG_H_W     = 13;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned IN_PIX_W    = 16;
  localparam int unsigned MAG_W       = 21;
  localparam int unsigned DIR_W       = 16;
  localparam int unsigned DIRQ_W      = 15;
  localparam int unsigned IN_ROW_W    = 13;
  localparam int unsigned OUT_ROW_W   = 12;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned WIDE_W      = 32;
  localparam int unsigned NORM_W      = 16;
  localparam int unsigned SUMSQ_W     = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_SCALE_X = 2'd2,
    REG_SCALE_Y = 2'd3
  } cfg_reg_e;

  // per-item control handed from the front end to the back end
  typedef struct packed {
    logic do_emit;
    logic do_write;
    logic has_left;
    logic has_right;
    logic has_above;
    logic use_pix;
    logic fend;
  } op_flags_t;

endpackage

@@ hw/rtl/cdg_queue.sv @@
// Small FIFO between the front end and the back end.
module cdg_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] head_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/cdg_front.sv @@
// Front end: raster position tracking and per-beat classification.
module cdg_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cdg_pkg::IMG_W_W-1:0]  image_width_i,
  input  logic [cdg_pkg::IMG_H_W-1:0]  image_height_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [cdg_pkg::IN_PIX_W-1:0] pixel_value_i,
  output logic                         push_o,
  input  logic                         full_i,
  output cdg_pkg::op_flags_t           flags_o,
  output logic                         out_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col_o,
  output logic                         wr_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_col_o,
  output logic [PIXEL_BITS-1:0]        pix_o
);
  import cdg_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (WW > IMG_W_W) ? WW : IMG_W_W;

  logic [CW-1:0]        in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [WW-1:0]        eff_w;
  logic [IMG_H_W-1:0]   eff_h;
  logic                 accept, all_in, out_last_col, out_last_row, fend;
  logic [CW:0]          in_col_inc, out_col_inc;
  logic [IMG_H_W-1:0]   out_row_inc;

  always_comb begin
    if (image_width_i == '0) begin
      eff_w = WW'(1);
    end else if (CMP_W'(image_width_i) > CMP_W'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_i);
    end
    if (image_height_i == '0) begin
      eff_h = IMG_H_W'(1);
    end else if (image_height_i > IMG_H_W'(MAX_HEIGHT)) begin
      eff_h = IMG_H_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_i;
    end
  end

  assign in_ready_o   = !full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign all_in       = (in_row_q >= eff_h);
  assign in_col_inc   = {1'b0, in_col_q} + 1'b1;
  assign out_col_inc  = {1'b0, out_col_q} + 1'b1;
  assign out_row_inc  = {1'b0, out_row_q} + 1'b1;
  assign out_last_col = (out_col_inc >= (CW+1)'(eff_w));
  assign out_last_row = (out_row_inc >= eff_h);
  assign fend         = all_in && out_last_row && out_last_col;

  always_comb begin
    flags_o           = '0;
    flags_o.has_left  = (out_col_q != '0);
    flags_o.has_right = !out_last_col;
    flags_o.has_above = (out_row_q != '0);
    flags_o.fend      = fend;
    flags_o.do_emit   = all_in || (!command_i && (in_row_q != '0));
    flags_o.do_write  = !all_in && !command_i;
    flags_o.use_pix   = !all_in && !out_last_row;
  end

  assign push_o     = accept && (all_in || !command_i);
  assign out_slot_o = out_row_q[0];
  assign out_col_o  = out_col_q;
  assign wr_slot_o  = in_row_q[0];
  assign wr_col_o   = in_col_q;
  assign pix_o      = pixel_value_i[PIXEL_BITS-1:0];

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept) begin
      if (fend) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (flags_o.do_emit) begin
        if (out_last_col) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_inc[CW-1:0];
        end
      end
      if (flags_o.do_write) begin
        if (in_col_inc >= (CW+1)'(eff_w)) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
        end else begin
          in_col_d = in_col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

@@ hw/rtl/cdg_dir_unit.sv @@
// Bit-serial search for one Q1.14 direction component.
module cdg_dir_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cdg_pkg::NORM_W-1:0]   a_i,
  input  logic [cdg_pkg::SUMSQ_W-1:0]  s_i,
  output logic                         done_o,
  output logic [cdg_pkg::DIRQ_W-1:0]   q_o
);
  import cdg_pkg::*;

  localparam int unsigned AW  = 52;
  localparam int unsigned BW  = 69;
  localparam int unsigned RW  = 2 * NORM_W + 30;
  localparam int unsigned JW  = $clog2(DIRQ_W);

  // q is found MSB first; with t = 2q-1, A tracks t*s and B tracks t*t*s
  logic signed [AW-1:0] acc_a_q, acc_a_d;
  logic signed [BW-1:0] acc_b_q, acc_b_d, cand_b;
  logic [RW-1:0]        rhs_q;
  logic [SUMSQ_W-1:0]   s_q;
  logic [DIRQ_W-1:0]    q_q, q_d;
  logic [JW-1:0]        j_q, j_d;
  logic                 run_q, run_d, done_q, done_d;
  logic [JW:0]          sh_a, sh_s;

  assign sh_a   = {1'b0, j_q} + (JW+1)'(2);
  assign sh_s   = {j_q, 1'b0} + (JW+1)'(2);
  assign cand_b = acc_b_q + (BW'(acc_a_q) <<< sh_a)
                + $signed(BW'({1'b0, s_q}) << sh_s);

  always_comb begin
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    q_d     = q_q;
    j_d     = j_q;
    run_d   = run_q;
    done_d  = done_q;
    if (start_i) begin
      acc_a_d = -$signed(AW'({1'b0, s_i}));
      acc_b_d = $signed(BW'({1'b0, s_i}));
      q_d     = '0;
      j_d     = JW'(DIRQ_W - 1);
      run_d   = 1'b1;
      done_d  = 1'b0;
    end else if (run_q) begin
      if (cand_b <= $signed(BW'({1'b0, rhs_q}))) begin
        q_d     = q_q | (DIRQ_W'(1) << j_q);
        acc_b_d = cand_b;
        acc_a_d = acc_a_q + $signed(AW'({1'b0, s_q}) << ({1'b0, j_q} + 1'b1));
      end
      if (j_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        j_d = j_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
    q_q     <= q_d;
    j_q     <= j_d;
    if (start_i) begin
      rhs_q <= {(2*NORM_W)'(a_i) * (2*NORM_W)'(a_i), 30'b0};
      s_q   <= s_i;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

@@ hw/rtl/cdg_back.sv @@
// Back end: two-line store, neighbor fetch, scaling, root and direction.
module cdg_back #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cdg_pkg::SCALE_W-1:0]  scale_x_i,
  input  logic [cdg_pkg::SCALE_W-1:0]  scale_y_i,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  cdg_pkg::op_flags_t           flags_i,
  input  logic                         out_slot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] out_col_i,
  input  logic                         wr_slot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col_i,
  input  logic [PIXEL_BITS-1:0]        pix_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cdg_pkg::MAG_W-1:0]    magnitude_o,
  output logic [cdg_pkg::DIR_W-1:0]    dir_x_o,
  output logic [cdg_pkg::DIR_W-1:0]    dir_y_o,
  output logic                         frame_end_o
);
  import cdg_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned AW  = CW + 1;
  localparam int unsigned SQW = 2 * WIDE_W + 1;
  localparam int unsigned VW  = SQW - 24;
  localparam int unsigned RTW = VW + 1;
  localparam int unsigned RT_STEPS = (VW + 1) / 2;
  localparam int unsigned STW = $clog2(RT_STEPS + 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_DIFF = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_NORM = 8'b0001_0000,
    ST_SQ   = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_ITER = 8'b1000_0000
  } bk_state_e;

  bk_state_e state_q, state_d;

  logic [PIXEL_BITS-1:0] mem_q [2**AW];
  logic [PIXEL_BITS-1:0] rdata_q;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  mem_we;
  logic [PIXEL_BITS-1:0] wr_data;

  op_flags_t             flags_q;
  logic                  oslot_q, wslot_q;
  logic [CW-1:0]         ocol_q, wcol_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [2:0]            rd_cnt_q;
  logic [PIXEL_BITS-1:0] ctr_q, lft_q, rgt_q, abv_q;
  logic [PIXEL_BITS-1:0] lft, rgt, blw, abv;
  logic signed [PIXEL_BITS:0] dxs, dys;
  logic [PIXEL_BITS-1:0] adx_q, ady_q;
  logic                  negx_q, negy_q, zero_q;
  logic [WIDE_W-1:0]     ax_q, ay_q, sx_q, sy_q;
  logic [2*WIDE_W-1:0]   x2_q, y2_q;
  logic [SUMSQ_W-1:0]    s_q;
  logic [RTW-1:0]        v_q, res_q, bit_q, trial;
  logic [STW-1:0]        step_q;
  logic                  rt_done, dx_done, dy_done, dir_start, finish;
  logic [DIRQ_W-1:0]     qx, qy;

  logic                  out_valid_q;
  logic [MAG_W-1:0]      mag_q;
  logic [DIR_W-1:0]      dirx_q, diry_q;
  logic                  fend_q;

  // line store: one write and one registered read per cycle
  always_comb begin
    case (rd_cnt_q)
      3'd0:    rd_addr = {oslot_q, ocol_q};
      3'd1:    rd_addr = {oslot_q, ocol_q - 1'b1};
      3'd2:    rd_addr = {oslot_q, ocol_q + 1'b1};
      default: rd_addr = {~oslot_q, ocol_q};
    endcase
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      mem_we  = q_valid_i && !flags_i.do_emit && flags_i.do_write;
      wr_addr = {wr_slot_i, wr_col_i};
      wr_data = pix_i;
    end else begin
      mem_we  = (state_q == ST_READ) && (rd_cnt_q == 3'd4) && flags_q.do_write;
      wr_addr = {wslot_q, wcol_q};
      wr_data = pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // out-of-frame neighbors fall back to the center
  assign lft = flags_q.has_left  ? lft_q : ctr_q;
  assign rgt = flags_q.has_right ? rgt_q : ctr_q;
  assign abv = flags_q.has_above ? abv_q : ctr_q;
  assign blw = flags_q.use_pix   ? pix_q : ctr_q;
  assign dxs = $signed({1'b0, rgt}) - $signed({1'b0, lft});
  assign dys = $signed({1'b0, blw}) - $signed({1'b0, abv});

  assign trial     = res_q + bit_q;
  assign rt_done   = (step_q == STW'(RT_STEPS));
  assign dir_start = (state_q == ST_SUM);
  assign finish    = (state_q == ST_ITER) && rt_done && dx_done && dy_done
                   && (!out_valid_q || out_ready_i);
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i && flags_i.do_emit) state_d = ST_READ;
      ST_READ: if (rd_cnt_q == 3'd4) state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_NORM;
      ST_NORM: if (((sx_q | sy_q) >> NORM_W) == '0) state_d = ST_SQ;
      ST_SQ:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_ITER;
      ST_ITER: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        flags_q  <= flags_i;
        oslot_q  <= out_slot_i;
        ocol_q   <= out_col_i;
        wslot_q  <= wr_slot_i;
        wcol_q   <= wr_col_i;
        pix_q    <= pix_i;
        rd_cnt_q <= 3'd0;
      end
      ST_READ: begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
        case (rd_cnt_q)
          3'd1:    ctr_q <= rdata_q;
          3'd2:    lft_q <= rdata_q;
          3'd3:    rgt_q <= rdata_q;
          3'd4:    abv_q <= rdata_q;
          default: ;
        endcase
      end
      ST_DIFF: begin
        negx_q <= dxs[PIXEL_BITS];
        negy_q <= dys[PIXEL_BITS];
        adx_q  <= dxs[PIXEL_BITS] ? PIXEL_BITS'(-dxs) : dxs[PIXEL_BITS-1:0];
        ady_q  <= dys[PIXEL_BITS] ? PIXEL_BITS'(-dys) : dys[PIXEL_BITS-1:0];
      end
      ST_MUL: begin
        ax_q <= WIDE_W'(adx_q) * WIDE_W'(scale_x_i);
        ay_q <= WIDE_W'(ady_q) * WIDE_W'(scale_y_i);
        sx_q <= WIDE_W'(adx_q) * WIDE_W'(scale_x_i);
        sy_q <= WIDE_W'(ady_q) * WIDE_W'(scale_y_i);
      end
      ST_NORM: begin
        if (((sx_q | sy_q) >> NORM_W) != '0) begin
          sx_q <= sx_q >> 1;
          sy_q <= sy_q >> 1;
        end
      end
      ST_SQ: begin
        x2_q   <= ax_q * ax_q;
        y2_q   <= ay_q * ay_q;
        s_q    <= SUMSQ_W'(WIDE_W'(sx_q[NORM_W-1:0]) * WIDE_W'(sx_q[NORM_W-1:0]))
                + SUMSQ_W'(WIDE_W'(sy_q[NORM_W-1:0]) * WIDE_W'(sy_q[NORM_W-1:0]));
        zero_q <= (ax_q == '0) && (ay_q == '0);
      end
      ST_SUM: begin
        v_q    <= RTW'((SQW'(x2_q) + SQW'(y2_q)) >> 24);
        res_q  <= '0;
        bit_q  <= RTW'(1) << (2 * (RT_STEPS - 1));
        step_q <= '0;
      end
      ST_ITER: begin
        if (!rt_done) begin
          if (v_q >= trial) begin
            v_q   <= v_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          step_q <= step_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (finish) begin
      mag_q  <= MAG_W'(res_q);
      dirx_q <= zero_q ? '0 : (negx_q ? -DIR_W'(qx) : DIR_W'(qx));
      diry_q <= zero_q ? '0 : (negy_q ? -DIR_W'(qy) : DIR_W'(qy));
      fend_q <= flags_q.fend;
    end
  end

  cdg_dir_unit u_dir_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dir_start),
    .a_i     (sx_q[NORM_W-1:0]),
    .s_i     (s_q),
    .done_o  (dx_done),
    .q_o     (qx)
  );

  cdg_dir_unit u_dir_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dir_start),
    .a_i     (sy_q[NORM_W-1:0]),
    .s_i     (s_q),
    .done_o  (dy_done),
    .q_o     (qy)
  );

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign dir_x_o     = dirx_q;
  assign dir_y_o     = diry_q;
  assign frame_end_o = fend_q;

endmodule

@@ hw/rtl/central_difference_gradient_2d_unit.sv @@
// Central-difference gradient unit: takes raster-order pixels (drain beats flush the
// last row) and gives one magnitude/direction beat per pixel, one line behind the input.
// The front end accepts one beat per cycle while its 4-entry queue has room; the back end
// handles one queued item at a time: a store-only pixel is written in the idle state; an
// output pixel needs line-store reads of center, left, right and upper neighbors via the
// single read port, a normalizing shift of up to 16 steps, a 21-step square root and the
// direction searches; the back end sets throughput. No clearing pass after reset.
module central_difference_gradient_2d_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cdg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cdg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [cdg_pkg::IN_PIX_W-1:0]    pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cdg_pkg::MAG_W-1:0]       magnitude_o,
  output logic signed [cdg_pkg::DIR_W-1:0] dir_x_o,
  output logic signed [cdg_pkg::DIR_W-1:0] dir_y_o,
  output logic                            frame_end_o
);
  import cdg_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = $bits(op_flags_t) + 2 * (CW + 1) + PIXEL_BITS;

  logic [IMG_W_W-1:0] image_width_q;
  logic [IMG_H_W-1:0] image_height_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMG_W_W'(2048);
      image_height_q <= IMG_H_W'(2048);
      scale_x_q      <= SCALE_W'(4096);
      scale_y_q      <= SCALE_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:   image_width_q  <= cfg_data_i[IMG_W_W-1:0];
        REG_HEIGHT:  image_height_q <= cfg_data_i[IMG_H_W-1:0];
        REG_SCALE_X: scale_x_q      <= cfg_data_i;
        REG_SCALE_Y: scale_y_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                  push, full, pop, q_valid;
  op_flags_t             f_flags, b_flags;
  logic                  f_oslot, f_wslot, b_oslot, b_wslot;
  logic [CW-1:0]         f_ocol, f_wcol, b_ocol, b_wcol;
  logic [PIXEL_BITS-1:0] f_pix, b_pix;
  logic [QW-1:0]         q_in, q_head;
  logic [DIR_W-1:0]      dir_x, dir_y;

  cdg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .pixel_value_i  (pixel_value_i),
    .push_o         (push),
    .full_i         (full),
    .flags_o        (f_flags),
    .out_slot_o     (f_oslot),
    .out_col_o      (f_ocol),
    .wr_slot_o      (f_wslot),
    .wr_col_o       (f_wcol),
    .pix_o          (f_pix)
  );

  assign q_in = {f_flags, f_oslot, f_ocol, f_wslot, f_wcol, f_pix};
  assign {b_flags, b_oslot, b_ocol, b_wslot, b_wcol, b_pix} = q_head;

  cdg_queue #(
    .DW    (QW),
    .DEPTH (4)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  cdg_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_x_i   (scale_x_q),
    .scale_y_i   (scale_y_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .flags_i     (b_flags),
    .out_slot_i  (b_oslot),
    .out_col_i   (b_ocol),
    .wr_slot_i   (b_wslot),
    .wr_col_i    (b_wcol),
    .pix_i       (b_pix),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .dir_x_o     (dir_x),
    .dir_y_o     (dir_y),
    .frame_end_o (frame_end_o)
  );

  assign dir_x_o = $signed(dir_x);
  assign dir_y_o = $signed(dir_y);

  // queue handshake consistency
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");

  // input ready is exactly the queue having room
  a_in_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !full) else $error("input ready out of step with queue");

endmodule

@@ dv/central_difference_gradient_2d_unit_test.sv @@
// Self-checking testbench for the central-difference gradient unit.
module central_difference_gradient_2d_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cdg_pkg::*;

  localparam int unsigned LINE_MAX   = 2048;
  localparam int unsigned DRAIN_WAIT = 80;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_y;
    logic             frame_end;
  } grad_pix_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  command_i;
  logic [IN_PIX_W-1:0]   pixel_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [MAG_W-1:0]      magnitude_o;
  logic signed [DIR_W-1:0] dir_x_o;
  logic signed [DIR_W-1:0] dir_y_o;
  logic                  frame_end_o;

  central_difference_gradient_2d_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .magnitude_o   (magnitude_o),
    .dir_x_o       (dir_x_o),
    .dir_y_o       (dir_y_o),
    .frame_end_o   (frame_end_o)
  );

  // predictor state
  logic [15:0]          pix_lines [2*LINE_MAX];
  int unsigned          in_col, in_row, out_col, out_row;
  logic [IMG_W_W-1:0]   width_q;
  logic [IMG_H_W-1:0]   height_q;
  logic [SCALE_W-1:0]   scale_x_q, scale_y_q;
  bit                   frame_closed;

  grad_pix_t            grad_expected [$];
  int unsigned          err_count;
  int unsigned          pixel_beats;
  longint unsigned      cycle_count;
  bit                   no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** central_difference_gradient_2d_unit: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned line_w();
    if (width_q == 0) return 1;
    if (width_q > LINE_MAX) return LINE_MAX;
    return width_q;
  endfunction

  function automatic int unsigned frame_h();
    if (height_q == 0) return 1;
    if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
    return height_q;
  endfunction

  function automatic int unsigned line_addr(int unsigned row, int unsigned col);
    return (row & 1) * LINE_MAX + col;
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // largest q in [0,16384] with (2q-1)^2 * s <= 2^30 * a^2 (rounded unit component)
  function automatic logic [63:0] unit_comp(logic [63:0] a, logic [63:0] s);
    logic [63:0] lo, hi, mid, t, rhs;
    lo  = 0;
    hi  = 16384;
    rhs = (a * a) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] signed_q14(bit neg, logic [63:0] q);
    logic [16:0] m;
    m = 17'h10000 - q[16:0];
    return neg ? m[15:0] : q[15:0];
  endfunction

  function automatic grad_pix_t gradient_at(bit have_below, longint below_val, bit fend);
    int unsigned w, h, r, c, k;
    longint center, left, right, above, below, x, y;
    logic [63:0] ax, ay, x2, y2, m24, sum_hi, mag, dx, dy, sx, sy, s;
    grad_pix_t g;
    w = line_w();
    h = frame_h();
    r = out_row;
    c = out_col;
    center = pix_lines[line_addr(r, c)];
    left   = (c >= 1) ? longint'(pix_lines[line_addr(r, c - 1)]) : center;
    right  = (c + 1 < w) ? longint'(pix_lines[line_addr(r, c + 1)]) : center;
    above  = (r >= 1) ? longint'(pix_lines[line_addr(r - 1, c)]) : center;
    below  = (have_below && r + 1 < h) ? below_val : center;
    x  = (right - left) * longint'(scale_x_q);
    y  = (below - above) * longint'(scale_y_q);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    x2 = ax * ax;
    y2 = ay * ay;
    m24 = (64'd1 << 24) - 1;
    sum_hi = (x2 >> 24) + (y2 >> 24) + (((x2 & m24) + (y2 & m24)) >> 24);
    mag = sqrt_floor(sum_hi);
    if (mag > 64'd2097151) mag = 64'd2097151;
    dx = 0;
    dy = 0;
    if (ax != 0 || ay != 0) begin
      k = 0;
      while (((ax | ay) >> k) >= 64'd65536) k++;
      sx = ax >> k;
      sy = ay >> k;
      s  = sx * sx + sy * sy;
      dx = unit_comp(sx, s);
      dy = unit_comp(sy, s);
    end
    g.magnitude = mag[MAG_W-1:0];
    g.dir_x     = signed_q14(x < 0, dx);
    g.dir_y     = signed_q14(y < 0, dy);
    g.frame_end = fend;
    return g;
  endfunction

  function automatic void next_out(int unsigned w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row = (out_row + 1) & 12'hFFF;
    end
  endfunction

  // advance the predictor by one accepted beat; returns 1 when the beat is ignored
  function automatic bit gradient_step(bit cmd, logic [15:0] pix);
    int unsigned w, h;
    bit fend;
    w = line_w();
    h = frame_h();
    if (in_row >= h) begin
      fend = (out_row + 1 >= h) && (out_col + 1 >= w);
      grad_expected.push_back(gradient_at(1'b0, 0, fend));
      if (fend) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_closed = 1'b1;
      end else begin
        next_out(w);
      end
      return 1'b0;
    end
    if (cmd) return 1'b1;
    if (in_row >= 1) begin
      grad_expected.push_back(gradient_at(1'b1, longint'(pix), 1'b0));
      next_out(w);
    end
    pix_lines[line_addr(in_row, in_col)] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row = (in_row + 1) & 13'h1FFF;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(bit cmd, logic [15:0] pix);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!gradient_step(cmd, pix)) pixel_beats++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grad_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // all four registers on back-to-back edges; block must be idle
  task automatic set_frame(int unsigned w, int unsigned h, int unsigned sx, int unsigned sy);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= 16'(w);
    @(posedge clk_i);
    width_q    = IMG_W_W'(w);
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= 16'(h);
    @(posedge clk_i);
    height_q   = IMG_H_W'(h);
    cfg_idx_i  <= REG_SCALE_X;
    cfg_data_i <= 16'(sx);
    @(posedge clk_i);
    scale_x_q  = 16'(sx);
    cfg_idx_i  <= REG_SCALE_Y;
    cfg_data_i <= 16'(sy);
    @(posedge clk_i);
    scale_y_q  = 16'(sy);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [15:0] draw_pixel(int unsigned mode, logic [15:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 6)) - 16'd3;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // drives beats until the predictor sees the frame close; stray drains on the way when stray is set
  task automatic run_frame(int unsigned mode, bit stray, bit hold_mid);
    logic [15:0] base;
    int unsigned n;
    base = 16'($urandom);
    n = 0;
    frame_closed = 1'b0;
    while (!frame_closed) begin
      if (stray && $urandom_range(0, 15) == 0) send_beat(1'b1, 16'($urandom));
      else send_beat($urandom_range(0, 3) == 0 && in_row >= frame_h(), draw_pixel(mode, base));
      n++;
      if (hold_mid && n == 5) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (grad_expected.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_directed();
    set_frame(3, 3, 4096, 4096);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b1, 16'hFFFF);      // drain inside the frame: dropped
    send_beat(1'b0, 16'hFFFF);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hFFFF);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hFFFF);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hFFFF);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'h1234);      // pixel after frame acts as drain
    send_beat(1'b1, 16'h0000);
    send_beat(1'b1, 16'h0000);
    // flat frame, zero gradient
    set_frame(2, 2, 65535, 65535);
    repeat (4) send_beat(1'b0, 16'h5A5A);
    repeat (2) send_beat(1'b1, 16'h0000);
    // gradient shorter than one
    set_frame(2, 2, 1, 1);
    send_beat(1'b0, 16'd7);
    send_beat(1'b0, 16'd8);
    send_beat(1'b0, 16'd9);
    send_beat(1'b0, 16'd7);
    repeat (2) send_beat(1'b1, 16'h0000);
  endtask

  task automatic test_register_extremes();
    set_frame(0, 0, 0, 0);           // clamps to one pixel, zero scales
    run_frame(0, 1'b1, 1'b0);
    set_frame(1, 1, 65535, 1);
    run_frame(2, 1'b0, 1'b0);
    set_frame(12, 2, 4096, 65535);   // beats back to back
    no_idle = 1'b1;
    run_frame(0, 1'b0, 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    bit held;
    goal = pixel_beats + 1400;
    held = 1'b0;
    while (pixel_beats < goal) begin
      set_frame($urandom_range(1, 12), $urandom_range(1, 8),
                ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 65535),
                ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 65535));
      no_idle = ($urandom_range(0, 5) == 0);
      run_frame($urandom_range(0, 2), $urandom_range(0, 3) == 0, !held);
      held = 1'b1;
      no_idle = 1'b0;
    end
  endtask

  // tall frame cut short: height lowered once the block is idle mid-frame
  task automatic test_height_change();
    set_frame(1, 8191, 4096, 4096);
    frame_closed = 1'b0;
    repeat (150) send_beat(1'b0, 16'($urandom));
    set_frame(1, 3, 4096, 4096);
    while (!frame_closed) send_beat(1'b1, 16'h0000);
  endtask

  // result checker with random back-pressure
  initial begin
    int unsigned stall;
    grad_pix_t exp_pix;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (grad_expected.size() == 0) begin
        $display("%0t unexpected beat: mag %0d dx %0d dy %0d fe %0b", $realtime,
                 magnitude_o, dir_x_o, dir_y_o, frame_end_o);
        err_count++;
      end else begin
        exp_pix = grad_expected.pop_front();
        if (magnitude_o !== exp_pix.magnitude) begin
          $display("%0t magnitude: expected %0d actual %0d", $realtime,
                   exp_pix.magnitude, magnitude_o);
          err_count++;
        end
        if (dir_x_o !== exp_pix.dir_x) begin
          $display("%0t dir_x: expected %0d actual %0d", $realtime,
                   $signed(exp_pix.dir_x), dir_x_o);
          err_count++;
        end
        if (dir_y_o !== exp_pix.dir_y) begin
          $display("%0t dir_y: expected %0d actual %0d", $realtime,
                   $signed(exp_pix.dir_y), dir_y_o);
          err_count++;
        end
        if (frame_end_o !== exp_pix.frame_end) begin
          $display("%0t frame_end: expected %0b actual %0b", $realtime,
                   exp_pix.frame_end, frame_end_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = 1'b0;
    pixel_value_i = '0;
    cycle_count   = 0;
    err_count     = 0;
    pixel_beats   = 0;
    no_idle       = 1'b0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    width_q   = 12'd2048;
    height_q  = 13'd2048;
    scale_x_q = 16'd4096;
    scale_y_q = 16'd4096;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random_frames();
    test_height_change();
    wait_idle();
    if (err_count == 0) begin
      $display("** central_difference_gradient_2d_unit: PASSED **");
    end else begin
      $display("** central_difference_gradient_2d_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cdg_pkg.sv
hw/rtl/cdg_queue.sv
hw/rtl/cdg_front.sv
hw/rtl/cdg_dir_unit.sv
hw/rtl/cdg_back.sv
hw/rtl/central_difference_gradient_2d_unit.sv
dv/central_difference_gradient_2d_unit_test.sv
